### hw/rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int WORD_BITS     = 31;
	localparam int PROD_BITS     = 2 * WORD_BITS;
	localparam int CFG_DATA_BITS = 31;
	localparam int CFG_IDX_BITS  = 2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODULUS  = 2'd0,
		REG_EXPONENT = 2'd1
	} reg_idx_t;

	localparam word_t MODULUS_RESET  = word_t'(2);
	localparam word_t EXPONENT_RESET = word_t'(0);

	// request to the shared modular multiplier
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mm_req_t;

endpackage

### hw/rtl/mexp_modmul.sv
// Multi-cycle modular multiplier: one product, then bit-serial reduction.
`timescale 1ns / 1ps

module mexp_modmul (
	input  logic             clk,
	input  logic             arst_n,
	input  mexp_pkg::mm_req_t req,
	input  mexp_pkg::word_t  modulus,
	output logic             done,
	output mexp_pkg::word_t  result
);
	import mexp_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS);

	typedef enum logic {
		MM_IDLE,
		MM_RED
	} mm_state_t;

	mm_state_t            state_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 done_q;
	word_t                r_q;
	word_t                low_q;

	logic [PROD_BITS-1:0] prod;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;
	word_t                r_next;

	assign prod = PROD_BITS'(req.a) * PROD_BITS'(req.b);

	// shift in the next product bit; remainder stays below the modulus
	assign trial  = {r_q, low_q[WORD_BITS-1]};
	assign diff   = trial - {1'b0, modulus};
	assign r_next = (trial >= {1'b0, modulus}) ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MM_IDLE: begin
					if (req.start) begin
						// high half is below the modulus when the operands are
						r_q     <= prod[PROD_BITS-1:WORD_BITS];
						low_q   <= prod[WORD_BITS-1:0];
						cnt_q   <= '0;
						state_q <= MM_RED;
					end
				end
				MM_RED: begin
					r_q   <= r_next;
					low_q <= {low_q[WORD_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(WORD_BITS - 1)) begin
						done_q  <= 1'b1;
						state_q <= MM_IDLE;
					end
				end
				default: state_q <= MM_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

### hw/rtl/modular_exponentiation_unit.sv
// Top level: config registers and square-and-multiply sequencer.
//
// Usage: write modulus (index 0) and exponent (index 1) on the write port
// while the block is idle; writes to other indexes are dropped. Each request
// on the input channel (in_valid high, in_stall low) carries one base_value
// and yields exactly one power_result = base_value^exponent mod modulus on
// the output channel, in request order.
// in_stall stays high from the accepting edge until the result has moved to
// the output register; one request is worked on at a time.
// Sequence: every modular multiply runs on the shared multiplier (one
// product, then one reduction bit per cycle). The base is reduced first,
// then each exponent bit up to the top set bit costs one scan, a multiply
// when set, and a square when higher bits remain; then the output register
// is loaded. A modulus below two skips the multiplier (result 0). The next
// request can be taken in the cycle after the output register is loaded.
// Output: power_result is held while out_stall is high; a new request is
// taken while a finished result still waits.
// Reset: asynchronous, active low; modulus returns to 2, exponent to 0, and
// any request in flight is dropped.
`timescale 1ns / 1ps

module modular_exponentiation_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [mexp_pkg::CFG_IDX_BITS-1:0]      wr_index,
	input  logic [mexp_pkg::CFG_DATA_BITS-1:0]     wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  mexp_pkg::word_t                        base_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output mexp_pkg::word_t                        power_result
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BASE,
		S_SCAN,
		S_MUL,
		S_SQR,
		S_OUT
	} seq_state_t;

	seq_state_t state_q;
	word_t      modulus_q;
	word_t      exponent_q;
	word_t      base_q;
	word_t      acc_q;
	word_t      exp_q;
	logic       out_valid_q;
	word_t      power_result_q;

	mm_req_t    mm_req;
	logic       mm_done;
	word_t      mm_result;
	logic       accept;
	logic       exp_high_zero;
	logic       out_load;

	assign accept        = in_valid && (state_q == S_IDLE);
	assign exp_high_zero = (exp_q[WORD_BITS-1:1] == '0);
	assign out_load      = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RESET;
			exponent_q <= EXPONENT_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_MODULUS)
				modulus_q <= wr_data[WORD_BITS-1:0];
			else if (wr_index == REG_EXPONENT)
				exponent_q <= wr_data[WORD_BITS-1:0];
		end
	end

	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = base_q;
		mm_req.b     = base_q;
		unique case (state_q)
			S_IDLE: begin
				// reduce the raw base first: base * 1
				mm_req.start = accept && (modulus_q[WORD_BITS-1:1] != '0);
				mm_req.a     = base_value;
				mm_req.b     = word_t'(1);
			end
			S_SCAN: begin
				if (exp_q != '0) begin
					mm_req.start = 1'b1;
					if (exp_q[0])
						mm_req.a = acc_q;
				end
			end
			S_MUL: mm_req.start = mm_done && !exp_high_zero;
			default: ;
		endcase
	end

	mexp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req),
		.modulus (modulus_q),
		.done    (mm_done),
		.result  (mm_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result or retire the accepted one
			if (out_load || (out_valid_q && !out_stall))
				out_valid_q <= out_load;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						exp_q <= exponent_q;
						if (modulus_q[WORD_BITS-1:1] == '0) begin
							acc_q   <= '0;
							state_q <= S_OUT;
						end else begin
							acc_q   <= word_t'(1);
							state_q <= S_BASE;
						end
					end
				end
				S_BASE: begin
					if (mm_done) begin
						base_q  <= mm_result;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (exp_q == '0)
						state_q <= S_OUT;
					else if (exp_q[0])
						state_q <= S_MUL;
					else
						state_q <= S_SQR;
				end
				S_MUL: begin
					if (mm_done) begin
						acc_q <= mm_result;
						// no higher bits: the final square is not needed
						if (exp_high_zero) begin
							exp_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (mm_done) begin
						base_q  <= mm_result;
						exp_q   <= {1'b0, exp_q[WORD_BITS-1:1]};
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (out_load) begin
						power_result_q <= acc_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = power_result_q;

endmodule

### hw/rtl/mexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top.
`timescale 1ns / 1ps

module mexp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input mexp_pkg::word_t                    power_result
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(power_result))
		else $error("stalled result changed");

	// one request at a time: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// a result never shows up the cycle after its request
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

	// reset clears the output channel
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (.*);

### tb/sv/modular_exponentiation_unit_tb.sv
// Self-checking testbench for the modular exponentiation unit.
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
	import mexp_pkg::*;

	localparam int    LIMIT_CYCLES = 5_000_000;
	localparam int    LONG_HOLD    = 800;
	localparam int    SETTLE       = 2100;  // worst-case exponentiation plus margin
	localparam int    RAND_ITEMS   = 480;
	localparam word_t WORD_MAX     = '1;

	// indexes with no register behind them
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED0 = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED1 = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]  wr_index = '0;
	logic [CFG_DATA_BITS-1:0] wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	word_t                    base_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	word_t                    power_result;

	word_t pending_bases[$];
	word_t expected_powers[$];
	word_t cur_modulus  = MODULUS_RESET;
	word_t cur_exponent = EXPONENT_RESET;
	word_t want;

	bit req_fire = 1'b0;
	bit rsp_fire = 1'b0;
	int tx_idle_pct = 28;
	int rx_idle_pct = 28;
	int rx_hold_left = 0;
	int req_count = 0;
	int rsp_count = 0;
	int cfg_writes = 0;
	int err_count = 0;
	int cycle_count = 0;

	modular_exponentiation_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.base_value   (base_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_result (power_result)
	);

	always #1 clk = ~clk;

	// right-to-left square-and-multiply with 64-bit products
	function automatic word_t mod_power(word_t base, word_t expo, word_t modn);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] m;
		int          i;
		acc = 64'd1;
		m   = 64'(modn);
		if (m < 64'd2)
			return '0;
		sq = 64'(base) % m;
		for (i = 0; i < WORD_BITS; i++) begin
			if (expo[i])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return word_t'(acc);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input word_t data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == REG_MODULUS)
			cur_modulus = data;
		else if (idx == REG_EXPONENT)
			cur_exponent = data;
		cfg_writes++;
	endtask

	// wait until every queued request has been sent and answered
	task automatic drain();
		do
			@(posedge clk);
		while (pending_bases.size() != 0 || in_valid || expected_powers.size() != 0);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				expected_powers.size());
			$display("[modular_exponentiation_unit] ERROR");
			$finish;
		end
	end

	// monitor: check results, predict on every accepted request
	always @(posedge clk) begin
		req_fire = arst_n && in_valid && !in_stall;
		rsp_fire = arst_n && out_valid && !out_stall;
		if (rsp_fire) begin
			rsp_count++;
			if (expected_powers.size() == 0) begin
				err_count++;
				$display("%0t: unexpected power_result, expected none, actual %0d",
					$time, power_result);
			end else begin
				want = expected_powers.pop_front();
				if (power_result !== want) begin
					err_count++;
					$display("%0t: power_result mismatch, expected %0d, actual %0d",
						$time, want, power_result);
				end
			end
		end
		if (req_fire) begin
			expected_powers.push_back(mod_power(base_value, cur_exponent, cur_modulus));
			req_count++;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!in_valid || req_fire) begin
			if (pending_bases.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				base_value <= pending_bases.pop_front();
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	initial begin
		int    ph;
		int    n;
		int    k;
		int    bits;
		int    rand_target;
		word_t m;
		word_t e;
		word_t b;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset configuration: modulus 2, exponent 0
		pending_bases.push_back('0);
		pending_bases.push_back(WORD_MAX);
		drain();

		// degenerate moduli answer 0
		write_reg(REG_MODULUS, '0);
		pending_bases.push_back(31'h2AAAAAAA);
		drain();
		write_reg(REG_MODULUS, word_t'(1));
		pending_bases.push_back(WORD_MAX);
		drain();

		// widest modulus and exponent, base at and around the modulus
		write_reg(REG_MODULUS, WORD_MAX);
		write_reg(REG_EXPONENT, WORD_MAX);
		pending_bases.push_back('0);
		pending_bases.push_back(word_t'(1));
		pending_bases.push_back(word_t'(2));
		pending_bases.push_back(WORD_MAX - 1);
		pending_bases.push_back(WORD_MAX);
		drain();

		// exponent zero, zero base included
		write_reg(REG_EXPONENT, '0);
		pending_bases.push_back(WORD_MAX);
		pending_bases.push_back('0);
		drain();

		write_reg(REG_MODULUS, word_t'(1000));
		write_reg(REG_EXPONENT, word_t'(1));
		pending_bases.push_back(word_t'(999));
		pending_bases.push_back(word_t'(1000));
		pending_bases.push_back(word_t'(12345));
		drain();

		// writes to unmapped indexes must leave the setting alone
		write_reg(REG_UNUSED0, WORD_MAX);
		write_reg(REG_UNUSED1, '0);
		pending_bases.push_back(word_t'(12345));
		drain();

		// small RSA key pair round trip
		write_reg(REG_MODULUS, word_t'(3233));
		write_reg(REG_EXPONENT, word_t'(17));
		pending_bases.push_back(word_t'(65));
		drain();
		write_reg(REG_EXPONENT, word_t'(2753));
		pending_bases.push_back(word_t'(2790));
		drain();

		rand_target = req_count + RAND_ITEMS;
		for (ph = 0; req_count < rand_target; ph++) begin
			tx_idle_pct = (ph == 3 || ph == 4) ? 0 : 28;
			rx_idle_pct = tx_idle_pct;
			case ($urandom_range(9))
				0:       m = word_t'($urandom_range(1));
				1, 2:    m = word_t'($urandom_range(16, 2));
				3, 4:    m = word_t'($urandom_range(65535, 17));
				default: m = word_t'($urandom());
			endcase
			if (ph % 8 == 6) begin
				e = word_t'($urandom());
				n = 8;
			end else begin
				bits = $urandom_range(10, 1);
				e    = word_t'($urandom()) & word_t'((32'd1 << bits) - 1);
				n    = $urandom_range(40, 20);
			end
			// short exponent so the block turns around quickly under back-pressure
			if (ph == 2) begin
				m = WORD_MAX;
				e = word_t'(3);
			end
			if ($urandom_range(1)) begin
				write_reg(REG_MODULUS, m);
				write_reg(REG_EXPONENT, e);
			end else begin
				write_reg(REG_EXPONENT, e);
				write_reg(REG_MODULUS, m);
			end
			if ($urandom_range(5) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED1 : REG_UNUSED0, word_t'($urandom()));
			if (ph == 2) begin
				@(posedge clk);
				rx_hold_left = LONG_HOLD;
			end
			for (k = 0; k < n; k++) begin
				case ($urandom_range(5))
					0: begin
						case ($urandom_range(3))
							0:       b = '0;
							1:       b = WORD_MAX;
							2:       b = m - 1;
							default: b = m;
						endcase
					end
					1:       b = word_t'($urandom_range(255));
					2, 3:    b = (m >= 2) ? word_t'($urandom_range(m - 1)) : word_t'($urandom());
					default: b = word_t'($urandom());
				endcase
				pending_bases.push_back(b);
			end
			drain();
		end

		repeat (SETTLE) @(negedge clk);

		$display("Sent %0d requests, checked %0d results, %0d register writes over %0d random settings.",
			req_count, rsp_count, cfg_writes, ph);
		$display("Covered degenerate and full-width moduli, zero and full-width exponents, "
			, "unmapped register writes and long output back-pressure.");
		if (err_count == 0)
			$display("[modular_exponentiation_unit] OK");
		else
			$display("[modular_exponentiation_unit] ERROR");
		$finish;
	end

endmodule
